### rtl/bellman_ford_shortest_paths_assert.svh
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication, held off during reset
`define BFSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bfsp assertion failed");

// next-cycle implication, held off during reset
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bfsp assertion failed");

`endif

### rtl/bfsp_pkg.sv
package bfsp_pkg;

    localparam int NODE_COUNT  = 16;
    localparam int NODE_BITS   = 4;
    localparam int EDGE_BITS   = 2 * NODE_BITS;
    localparam int EDGE_COUNT  = NODE_COUNT * NODE_COUNT;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 32;

    typedef logic [NODE_BITS-1:0]          t_node;
    typedef logic [EDGE_BITS-1:0]          t_edge;
    typedef logic signed [WEIGHT_BITS-1:0] t_weight;
    typedef logic signed [DIST_BITS-1:0]   t_dist;

    localparam t_dist DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam t_dist DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    // wide sum of distance and weight, clamped to the distance range
    function automatic t_dist sat_add(t_dist d, t_weight w);
        logic signed [DIST_BITS:0] sum;
        sum = {d[DIST_BITS-1], d} + (DIST_BITS+1)'(w);
        if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
            sat_add = sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
        end else begin
            sat_add = sum[DIST_BITS-1:0];
        end
    endfunction

endpackage

### rtl/bfsp_ram.sv
module bfsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bellman_ford_shortest_paths.sv
// Bellman-Ford shortest paths over a 16 x 16 signed weight matrix.
// Input items (start/busy): each accepted item writes one matrix entry
// {i_from_node, i_to_node} <= i_edge_weight; weight zero means no edge.
// Loading accepts one item per cycle, busy stays low while i_last_entry is 0.
// An item with i_last_entry set writes its entry and then starts a run from
// the source node held in the config register (i_cfg_we / i_cfg_wdata,
// written while busy is low).
// The run holds busy high: it seeds the source, then runs 15 relaxation
// passes and one check pass, each over all 256 entries in two steps per
// entry through a single shared add/saturate/compare unit (weight memory
// read, then compare and, in a relaxation pass, write back).
// Results follow, one per node in ascending order, each through the ORD
// and OUT states: o_result_strobe is high for exactly one cycle per item,
// 16 items, the last marked by o_last_result. Busy falls in the cycle that
// shows the last result. The receiver cannot hold results off.
// Reset clears the matrix (per-entry valid bits), the source register and
// the sequencer; the block is ready in the first cycle after reset.
module bellman_ford_shortest_paths
    import bfsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_from_node,
    input  logic [3:0]  i_to_node,
    input  logic signed [15:0] i_edge_weight,
    input  logic        i_last_entry,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    output logic        o_result_strobe,
    output logic [3:0]  o_node,
    output logic signed [31:0] o_distance,
    output logic        o_reached,
    output logic [3:0]  o_parent_node,
    output logic        o_has_parent,
    output logic        o_negative_cycle,
    output logic        o_last_result
);

`include "bellman_ford_shortest_paths_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_ORD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam t_node LAST_NODE = t_node'(NODE_COUNT - 1);

    logic [2:0] r_state, n_state;
    t_node      r_a, n_a;
    t_node      r_b, n_b;
    t_node      r_pass, n_pass;
    t_node      r_source;
    logic       r_neg, n_neg;
    logic       r_wv;

    logic [NODE_COUNT-1:0] r_reached;
    logic [NODE_COUNT-1:0] r_pvalid;
    logic [EDGE_COUNT-1:0] r_wvalid;

    logic  r_strobe;
    t_node r_o_node;
    t_dist r_o_dist;
    logic  r_o_reached;
    t_node r_o_parent;
    logic  r_o_has_parent;
    logic  r_o_neg;
    logic  r_o_last;

    logic    accept;
    logic    load_we;
    t_edge   load_addr;
    t_weight w_rdata;
    t_dist   da_rdata;
    t_dist   db_rdata;
    logic    dist_we;
    t_node   dist_waddr;
    t_dist   dist_wdata;
    logic    parent_we;
    t_node   parent_rdata;
    t_dist   cand;
    logic    improve;
    logic    relax_pass;
    logic    src_ok;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign load_addr = {i_from_node, i_to_node};
    assign load_we   = accept && (int'(i_from_node) < NODE_COUNT)
                       && (int'(i_to_node) < NODE_COUNT);
    assign src_ok    = int'(r_source) < NODE_COUNT;

    bfsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(EDGE_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (i_edge_weight),
        .i_raddr ({r_a, r_b}),
        .o_rdata (w_rdata)
    );

    // two copies of the distances so that both edge ends read in the same cycle
    bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(NODE_COUNT)) u_dist_a_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (r_a),
        .o_rdata (da_rdata)
    );

    bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(NODE_COUNT)) u_dist_b_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (r_b),
        .o_rdata (db_rdata)
    );

    bfsp_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_COUNT)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (parent_we),
        .i_waddr (r_b),
        .i_wdata (r_a),
        .i_raddr (r_a),
        .o_rdata (parent_rdata)
    );

    // shared relaxation unit
    assign relax_pass = (r_pass != LAST_NODE);
    assign cand       = sat_add(da_rdata, w_rdata);
    assign improve    = r_wv && (w_rdata != '0) && r_reached[r_a]
                        && (!r_reached[r_b] || (cand < db_rdata));
    assign parent_we  = (r_state == S_CMP) && relax_pass && improve;

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_b;
        dist_wdata = cand;
        if (r_state == S_INIT) begin
            dist_we    = 1'b1;
            dist_waddr = r_source;
            dist_wdata = '0;
        end else if (r_state == S_CMP && relax_pass && improve) begin
            dist_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_pass  = r_pass;
        n_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                if (accept && i_last_entry) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_a     = '0;
                n_b     = '0;
                n_pass  = '0;
                n_neg   = 1'b0;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!relax_pass && improve) begin
                    n_neg = 1'b1;
                end
                n_state = S_RD;
                n_b     = r_b + t_node'(1);
                if (r_b == LAST_NODE) begin
                    n_a = r_a + t_node'(1);
                    if (r_a == LAST_NODE) begin
                        if (relax_pass) begin
                            n_pass = r_pass + t_node'(1);
                        end else begin
                            n_state = S_ORD;
                        end
                    end
                end
            end
            S_ORD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_a = r_a + t_node'(1);
                if (r_a == LAST_NODE) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_a      <= '0;
            r_b      <= '0;
            r_pass   <= '0;
            r_neg    <= 1'b0;
            r_source <= '0;
            r_strobe <= 1'b0;
            r_wvalid <= '0;
            r_reached <= '0;
            r_pvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_a      <= n_a;
            r_b      <= n_b;
            r_pass   <= n_pass;
            r_neg    <= n_neg;
            r_strobe <= (r_state == S_OUT);
            if (i_cfg_we) begin
                r_source <= i_cfg_wdata;
            end
            if (load_we) begin
                r_wvalid[load_addr] <= 1'b1;
            end
            if (r_state == S_INIT) begin
                r_pvalid  <= '0;
                r_reached <= src_ok ? (NODE_COUNT'(1) << r_source) : '0;
            end else if (r_state == S_CMP && relax_pass && improve) begin
                r_reached[r_b] <= 1'b1;
                r_pvalid[r_b]  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wv <= r_wvalid[{r_a, r_b}];
        if (r_state == S_OUT) begin
            r_o_node       <= r_a;
            r_o_dist       <= r_reached[r_a] ? da_rdata : '0;
            r_o_reached    <= r_reached[r_a];
            r_o_parent     <= r_pvalid[r_a] ? parent_rdata : '0;
            r_o_has_parent <= r_pvalid[r_a];
            r_o_neg        <= r_neg;
            r_o_last       <= (r_a == LAST_NODE);
        end
    end

    assign o_result_strobe  = r_strobe;
    assign o_node           = r_o_node;
    assign o_distance       = r_o_dist;
    assign o_reached        = r_o_reached;
    assign o_parent_node    = r_o_parent;
    assign o_has_parent     = r_o_has_parent;
    assign o_negative_cycle = r_o_neg;
    assign o_last_result    = r_o_last;

    `BFSP_ASSERT_NOW(a_strobe_after_out, i_clk, i_rst_n, r_strobe, $past(r_state) == S_OUT)
    `BFSP_ASSERT_NOW(a_last_frees_block, i_clk, i_rst_n, r_strobe && r_o_last, !busy)
    `BFSP_ASSERT_NEXT(a_run_starts, i_clk, i_rst_n, accept && i_last_entry, r_state == S_INIT)
    `BFSP_ASSERT_NOW(a_neg_in_check, i_clk, i_rst_n, $rose(r_neg), $past(r_pass) == LAST_NODE)

endmodule
